// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the RTL. Every check is sampled on
// the rising clock edge and switched off while the synchronous reset is low.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check: when ante holds, cons must hold on the same edge
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold on the following edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/luhn_pkg.sv =====
// ============================================================================
// luhn_pkg
// Types, constants and helper functions for the Luhn card number classifier:
// pipeline stage payload, brand codes, BCD conversion step, Luhn digit sum.
// ============================================================================
package luhn_pkg;

    // Field and pipeline geometry
    localparam int NUM_W          = 63;   // card number width
    localparam int NUM_DIGITS     = 16;   // decimal digits checked
    localparam int BCD_W          = 4 * NUM_DIGITS;
    localparam int BITS_PER_STAGE = 4;    // binary bits converted per stage
    localparam int NUM_STAGES     = (NUM_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int SHIFT_W        = NUM_STAGES * BITS_PER_STAGE;
    localparam int SUM_W          = 8;    // Luhn sum is at most 144

    // Brand codes
    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_VISA       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_AMEX       = 2'd3
    } t_brand;

    // Powers of ten used by the prefix ranges
    localparam logic [NUM_W-1:0] E12 = 63'd1000000000000;
    localparam logic [NUM_W-1:0] E13 = 63'd10000000000000;
    localparam logic [NUM_W-1:0] E14 = 63'd100000000000000;
    localparam logic [NUM_W-1:0] E15 = 63'd1000000000000000;

    // Payload carried through the conversion stages
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;    // low 16 decimal digits so far
        logic [SHIFT_W-1:0] bits;   // binary bits still to convert, MSB first
        t_brand             brand;  // brand by prefix, before the checksum
    } t_dd;

    // One shift-add-3 step; digits above the low sixteen are dropped,
    // which never disturbs the low digits since carries only move up.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic b);
        logic [BCD_W-1:0] adj;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                     : bcd[4*i +: 4];
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Doubled digit with its two decimal digits added
    function automatic logic [3:0] dbl_digit(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Luhn sum over the sixteen digits as a balanced adder tree
    function automatic logic [SUM_W-1:0] luhn_sum(input logic [BCD_W-1:0] bcd);
        logic [3:0] d  [NUM_DIGITS];
        logic [4:0] l1 [NUM_DIGITS/2];
        logic [5:0] l2 [NUM_DIGITS/4];
        logic [6:0] l3 [NUM_DIGITS/8];
        for (int i = 0; i < NUM_DIGITS; i++) begin
            // odd positions from the right (zero based) are doubled
            d[i] = ((i & 1) != 0) ? dbl_digit(bcd[4*i +: 4]) : bcd[4*i +: 4];
        end
        for (int i = 0; i < NUM_DIGITS/2; i++) begin
            l1[i] = {1'b0, d[2*i]} + {1'b0, d[2*i+1]};
        end
        for (int i = 0; i < NUM_DIGITS/4; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < NUM_DIGITS/8; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        return {1'b0, l3[0]} + {1'b0, l3[1]};
    endfunction

    // Sum is a multiple of ten (sum never exceeds 144)
    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 14; k++) begin
            hit = hit | (s == SUM_W'(10 * k));
        end
        return hit;
    endfunction

    // Every nibble is a decimal digit
    function automatic logic bcd_digits_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            ok = ok & (bcd[4*i +: 4] <= 4'd9);
        end
        return ok;
    endfunction

    // Brand by leading digits, expressed as value ranges
    function automatic t_brand classify(input logic [NUM_W-1:0] v);
        logic visa, mc, amex;
        t_brand b;
        visa = (v >= 4 * E15 && v < 5 * E15) || (v >= 4 * E14 && v < 5 * E14) ||
               (v >= 4 * E13 && v < 5 * E13) || (v >= 4 * E12 && v < 5 * E12);
        mc   = (v >= 51 * E14 && v < 56 * E14);
        amex = (v >= 34 * E13 && v < 35 * E13) || (v >= 37 * E13 && v < 38 * E13);
        if (visa) begin
            b = BRAND_VISA;
        end else if (mc) begin
            b = BRAND_MASTERCARD;
        end else if (amex) begin
            b = BRAND_AMEX;
        end else begin
            b = BRAND_INVALID;
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/luhn_dd_stage.sv =====
// ============================================================================
// luhn_dd_stage
// One registered stage of the binary to BCD converter: folds four binary
// bits into the decimal digits, with a valid bit and a bubble-filling ready.
// ============================================================================
module luhn_dd_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  luhn_pkg::t_dd i_data,
    input  logic          i_ready_next,
    output logic          o_valid,
    output luhn_pkg::t_dd o_data,
    output logic          o_ready
);

    logic          r_valid;
    luhn_pkg::t_dd r_data;
    luhn_pkg::t_dd n_data;

    // Four shift-add-3 steps, MSB of the remaining bits first
    always_comb begin
        n_data = i_data;
        for (int j = 0; j < luhn_pkg::BITS_PER_STAGE; j++) begin
            n_data.bcd  = luhn_pkg::dd_step(n_data.bcd, n_data.bits[luhn_pkg::SHIFT_W-1]);
            n_data.bits = {n_data.bits[luhn_pkg::SHIFT_W-2:0], 1'b0};
        end
    end

    // Stage takes a transfer when empty or when its content moves on
    assign o_ready = !r_valid || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/luhn_card_number_classifier.sv =====
// ============================================================================
// luhn_card_number_classifier
// Luhn mod-10 check and brand classification of a binary card number.
// ============================================================================
// Takes one card number per cycle unless back-pressure from i_stall has
// filled the pipeline, and returns one result per number, in order. From
// input transfer to output valid a number passes one input register, 16
// binary-to-BCD conversion stages of four bits each, one Luhn sum stage and
// one output register. Every stage fills bubbles on its own, so new numbers
// keep entering while a finished result waits on i_stall until the pipeline
// is full. checksum_ok covers the low sixteen decimal digits; brand is
// nonzero only when the checksum passes and the leading digits match visa,
// mastercard or amex.
// ============================================================================
`include "assert_macros.svh"

module luhn_card_number_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [luhn_pkg::NUM_W-1:0] i_card_number,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_brand,
    output logic                       o_checksum_ok
);

    localparam int NS = luhn_pkg::NUM_STAGES;

    // Input register
    logic                       r_in_valid;
    logic [luhn_pkg::NUM_W-1:0] r_in_num;
    logic                       w_in_ready;

    // Conversion pipeline links
    logic          w_dd_valid [NS+1];
    luhn_pkg::t_dd w_dd_data  [NS+1];
    logic          w_dd_ready [NS+1];

    // Sum stage
    logic                       r_sum_valid;
    logic [luhn_pkg::SUM_W-1:0] r_sum;
    luhn_pkg::t_brand           r_sum_brand;
    logic                       w_sum_ready;
    logic                       w_sum_ok;

    // Output stage
    logic             r_out_valid;
    logic             r_out_ok;
    luhn_pkg::t_brand r_out_brand;
    logic             w_out_ready;

    // Input register: take a transfer when empty or moving on
    assign w_in_ready = !r_in_valid || w_dd_ready[0];
    assign o_stall    = !w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_valid;
        end
        if (w_in_ready && i_valid) begin
            r_in_num <= i_card_number;
        end
    end

    // Seed the converter; prefix classification rides along
    assign w_dd_valid[0]      = r_in_valid;
    assign w_dd_data[0].bcd   = '0;
    assign w_dd_data[0].bits  = {{(luhn_pkg::SHIFT_W - luhn_pkg::NUM_W){1'b0}}, r_in_num};
    assign w_dd_data[0].brand = luhn_pkg::classify(r_in_num);

    // Binary to BCD conversion stages
    for (genvar k = 0; k < NS; k++) begin : g_dd
        luhn_dd_stage u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (w_dd_valid[k]),
            .i_data       (w_dd_data[k]),
            .i_ready_next (w_dd_ready[k+1]),
            .o_valid      (w_dd_valid[k+1]),
            .o_data       (w_dd_data[k+1]),
            .o_ready      (w_dd_ready[k])
        );
    end

    assign w_dd_ready[NS] = w_sum_ready;

    // Luhn sum stage
    assign w_sum_ready = !r_sum_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (w_sum_ready) begin
            r_sum_valid <= w_dd_valid[NS];
        end
        if (w_sum_ready && w_dd_valid[NS]) begin
            r_sum       <= luhn_pkg::luhn_sum(w_dd_data[NS].bcd);
            r_sum_brand <= w_dd_data[NS].brand;
        end
    end

    // Mod-10 test and final brand
    assign w_sum_ok    = luhn_pkg::is_mult10(r_sum);
    assign w_out_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_sum_valid;
        end
        if (w_out_ready && r_sum_valid) begin
            r_out_ok    <= w_sum_ok;
            r_out_brand <= w_sum_ok ? r_sum_brand : luhn_pkg::BRAND_INVALID;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_checksum_ok = r_out_ok;
    assign o_brand       = r_out_brand;

    // Checks
    `ASSERT_SAME(a_empty_no_stall, i_clk, i_rst_n, !o_valid, !o_stall,
                 "input stalled while the output register is empty")
    `ASSERT_SAME(a_bcd_digits, i_clk, i_rst_n, w_dd_valid[NS],
                 luhn_pkg::bcd_digits_ok(w_dd_data[NS].bcd),
                 "converter produced a nibble above nine")
    `ASSERT_NEXT(a_sum_to_out, i_clk, i_rst_n, r_sum_valid && w_out_ready,
                 o_valid && (o_checksum_ok == $past(w_sum_ok)),
                 "checksum result lost between sum and output stage")

endmodule
